FILE: sv/qtd_pkg.sv
package qtd_pkg;

    localparam int QTD_NCOEF       = 10;
    localparam int QTD_QDEPTH      = 2;
    localparam int QTD_QPTR_W      = 1;
    localparam int QTD_SQRT_STEPS  = 32;
    localparam int QTD_DIV_STEPS   = 49;
    localparam int QTD_FRONT_STG   = 4;
    localparam int QTD_MUL_STG     = 2;
    localparam int QTD_DEPTH       = QTD_FRONT_STG + 3 * QTD_SQRT_STEPS + QTD_MUL_STG + 1
                                     + QTD_DIV_STEPS;

    localparam logic [3:0] CI_ONE = 4'd0;
    localparam logic [3:0] CI_X   = 4'd1;
    localparam logic [3:0] CI_Y   = 4'd2;
    localparam logic [3:0] CI_Z   = 4'd3;
    localparam logic [3:0] CI_XX  = 4'd4;
    localparam logic [3:0] CI_XY  = 4'd5;
    localparam logic [3:0] CI_XZ  = 4'd6;
    localparam logic [3:0] CI_YY  = 4'd7;
    localparam logic [3:0] CI_YZ  = 4'd8;
    localparam logic [3:0] CI_ZZ  = 4'd9;

    typedef logic signed [31:0] qtd_word_t;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_POINT = 1'b1
    } qtd_op_t;

    typedef struct packed
    {
        qtd_op_t    operation;
        logic [3:0] coeff_index;
        qtd_word_t  coeff_value;
        qtd_word_t  x_coord;
        qtd_word_t  y_coord;
        qtd_word_t  z_coord;
    } qtd_req_t;

    typedef struct packed
    {
        logic [31:0] distance_value;
        qtd_word_t   field_value;
        qtd_word_t   grad_x;
        qtd_word_t   grad_y;
        qtd_word_t   grad_z;
        logic        degenerate;
    } qtd_rsp_t;

    typedef struct packed
    {
        qtd_word_t [QTD_NCOEF-1:0] coeff;
        qtd_word_t                 x_coord;
        qtd_word_t                 y_coord;
        qtd_word_t                 z_coord;
    } qtd_job_t;

    typedef struct packed
    {
        logic [63:0] v;
        logic [63:0] r;
    } qtd_sqrt_t;

    typedef struct packed
    {
        qtd_word_t   fv;
        qtd_word_t   gx;
        qtd_word_t   gy;
        qtd_word_t   gz;
        logic [31:0] fmag;
        logic [63:0] sval;
        logic [31:0] groot;
        logic [31:0] aroot;
    } qtd_carry_t;

    function automatic qtd_word_t qtd_sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -48'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic qtd_word_t qtd_qmul(input qtd_word_t a, input qtd_word_t b);
        logic signed [63:0] p;
        p = a * b;
        return qtd_sat32($signed(p[63:16]));
    endfunction

    function automatic logic [63:0] qtd_sq(input qtd_word_t a);
        logic signed [63:0] p;
        p = a * a;
        return p;
    endfunction

    function automatic qtd_sqrt_t qtd_sqrt_step(input qtd_sqrt_t p, input int k);
        logic [63:0] bitv;
        logic [63:0] trial;
        qtd_sqrt_t   n;
        bitv  = 64'd1 << (62 - 2 * k);
        trial = p.r + bitv;
        if (p.v >= trial)
        begin
            n.v = p.v - trial;
            n.r = (p.r >> 1) + bitv;
        end
        else
        begin
            n.v = p.v;
            n.r = p.r >> 1;
        end
        return n;
    endfunction

endpackage

FILE: sv/qtd_front.sv
module qtd_front
    import qtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  qtd_req_t req,
    output logic     job_valid,
    input  logic     job_ready,
    output qtd_job_t job
);

    qtd_word_t [QTD_NCOEF-1:0] coeff_reg;
    logic                      accept;

    assign req_ready = job_ready;
    assign accept    = req_valid && req_ready;
    assign job_valid = req_valid && (req.operation == OP_POINT);

    assign job.coeff   = coeff_reg;
    assign job.x_coord = req.x_coord;
    assign job.y_coord = req.y_coord;
    assign job.z_coord = req.z_coord;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else if (accept && (req.operation == OP_LOAD) && (req.coeff_index < 4'(QTD_NCOEF)))
        begin
            coeff_reg[req.coeff_index] <= req.coeff_value;
        end
    end

endmodule

FILE: sv/qtd_fifo.sv
module qtd_fifo
    import qtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  qtd_job_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output qtd_job_t pop_data
);

    qtd_job_t              mem_reg [QTD_QDEPTH];
    logic [QTD_QPTR_W-1:0] wr_ptr_reg;
    logic [QTD_QPTR_W-1:0] rd_ptr_reg;
    logic [QTD_QPTR_W:0]   cnt_reg;
    logic                  push;
    logic                  pop;

    assign push_ready = (cnt_reg != (QTD_QPTR_W + 1)'(QTD_QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/qtd_isqrt.sv
module qtd_isqrt
    import qtd_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] value,
    input  qtd_carry_t  carry_in,
    output logic [31:0] root,
    output qtd_carry_t  carry_out
);

    qtd_sqrt_t  st_reg [QTD_SQRT_STEPS];
    qtd_carry_t cy_reg [QTD_SQRT_STEPS];

    genvar k;
    for (k = 0; k < QTD_SQRT_STEPS; k++)
    begin : g_step
        qtd_sqrt_t  prv;
        qtd_carry_t pcy;
        if (k == 0)
        begin : g_head
            assign prv = '{v: value, r: 64'd0};
            assign pcy = carry_in;
        end
        else
        begin : g_body
            assign prv = st_reg[k-1];
            assign pcy = cy_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= qtd_sqrt_step(prv, k);
                cy_reg[k] <= pcy;
            end
        end
    end

    assign root      = st_reg[QTD_SQRT_STEPS-1].r[31:0];
    assign carry_out = cy_reg[QTD_SQRT_STEPS-1];

endmodule

FILE: sv/qtd_back.sv
module qtd_back
    import qtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  qtd_job_t job,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output qtd_rsp_t rsp
);

    typedef struct packed
    {
        logic [33:0] rem;
        logic [48:0] num;
        logic [48:0] quo;
        logic [33:0] den;
        logic        degen;
        qtd_carry_t  carry;
    } qtd_div_t;

    function automatic qtd_div_t div_step(input qtd_div_t p);
        logic [34:0] t;
        qtd_div_t    n;
        n     = p;
        t     = {p.rem, p.num[48]};
        n.num = {p.num[47:0], 1'b0};
        if (t >= {1'b0, p.den})
        begin
            n.rem = 34'(t - {1'b0, p.den});
            n.quo = {p.quo[47:0], 1'b1};
        end
        else
        begin
            n.rem = t[33:0];
            n.quo = {p.quo[47:0], 1'b0};
        end
        return n;
    endfunction

    logic                   en;
    logic [QTD_DEPTH-1:0]   vld_reg;
    logic                   rsp_valid_reg;
    qtd_rsp_t               rsp_reg;

    qtd_word_t [QTD_NCOEF-1:0] s1_c_reg;
    qtd_word_t                 s1_pp_reg  [6];
    qtd_word_t                 s1_lin_reg [3];
    qtd_word_t                 s1_gp_reg  [9];
    logic [63:0]               s1_sq_reg  [6];

    logic signed [33:0] s2_lin_reg;
    qtd_word_t          s2_q_reg [6];
    qtd_word_t          s2_g_reg [3];
    logic [63:0]        s2_s_reg;
    logic signed [34:0] gx_sum;
    logic signed [34:0] gy_sum;
    logic signed [34:0] gz_sum;
    logic [65:0]        s_pure;
    logic [65:0]        s_mixed;
    logic [65:0]        s_tot;

    qtd_word_t          s3_f_reg;
    qtd_word_t          s3_g_reg   [3];
    logic [63:0]        s3_gsq_reg [3];
    logic [63:0]        s3_s_reg;
    logic signed [36:0] f_sum;

    qtd_carry_t  s4_carry_reg;
    logic [63:0] s4_gsum_reg;

    logic [31:0] root1;
    logic [31:0] root2;
    logic [31:0] root3;
    qtd_carry_t  carry1;
    qtd_carry_t  carry2;
    qtd_carry_t  carry3;
    qtd_carry_t  sq2_in;
    qtd_carry_t  m1_in;

    qtd_carry_t  m1_carry_reg;
    logic [63:0] m1_gg_reg;
    logic [63:0] m1_af_reg;
    qtd_carry_t  m2_carry_reg;
    logic [63:0] m2_rv_reg;

    qtd_div_t    d0_reg;
    qtd_div_t    dv_reg [QTD_DIV_STEPS];
    qtd_div_t    last;
    logic [31:0] dist_val;

    assign en        = !rsp_valid_reg || rsp_ready;
    assign job_ready = en;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[QTD_DEPTH-2:0], job_valid};
            rsp_valid_reg <= vld_reg[QTD_DEPTH-1];
        end
    end

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_c_reg      <= job.coeff;
            s1_pp_reg[0]  <= qtd_qmul(job.x_coord, job.x_coord);
            s1_pp_reg[1]  <= qtd_qmul(job.x_coord, job.y_coord);
            s1_pp_reg[2]  <= qtd_qmul(job.x_coord, job.z_coord);
            s1_pp_reg[3]  <= qtd_qmul(job.y_coord, job.y_coord);
            s1_pp_reg[4]  <= qtd_qmul(job.y_coord, job.z_coord);
            s1_pp_reg[5]  <= qtd_qmul(job.z_coord, job.z_coord);
            s1_lin_reg[0] <= qtd_qmul(job.coeff[CI_X], job.x_coord);
            s1_lin_reg[1] <= qtd_qmul(job.coeff[CI_Y], job.y_coord);
            s1_lin_reg[2] <= qtd_qmul(job.coeff[CI_Z], job.z_coord);
            s1_gp_reg[0]  <= qtd_qmul(job.coeff[CI_XX], job.x_coord);
            s1_gp_reg[1]  <= qtd_qmul(job.coeff[CI_XY], job.y_coord);
            s1_gp_reg[2]  <= qtd_qmul(job.coeff[CI_XZ], job.z_coord);
            s1_gp_reg[3]  <= qtd_qmul(job.coeff[CI_XY], job.x_coord);
            s1_gp_reg[4]  <= qtd_qmul(job.coeff[CI_YY], job.y_coord);
            s1_gp_reg[5]  <= qtd_qmul(job.coeff[CI_YZ], job.z_coord);
            s1_gp_reg[6]  <= qtd_qmul(job.coeff[CI_XZ], job.x_coord);
            s1_gp_reg[7]  <= qtd_qmul(job.coeff[CI_YZ], job.y_coord);
            s1_gp_reg[8]  <= qtd_qmul(job.coeff[CI_ZZ], job.z_coord);
            s1_sq_reg[0]  <= qtd_sq(job.coeff[CI_XX]);
            s1_sq_reg[1]  <= qtd_sq(job.coeff[CI_XY]);
            s1_sq_reg[2]  <= qtd_sq(job.coeff[CI_XZ]);
            s1_sq_reg[3]  <= qtd_sq(job.coeff[CI_YY]);
            s1_sq_reg[4]  <= qtd_sq(job.coeff[CI_YZ]);
            s1_sq_reg[5]  <= qtd_sq(job.coeff[CI_ZZ]);
        end
    end

    always_comb
    begin
        gx_sum  = 35'($signed(s1_c_reg[CI_X])) + (35'(s1_gp_reg[0]) <<< 1)
                  + 35'(s1_gp_reg[1]) + 35'(s1_gp_reg[2]);
        gy_sum  = 35'($signed(s1_c_reg[CI_Y])) + 35'(s1_gp_reg[3])
                  + (35'(s1_gp_reg[4]) <<< 1) + 35'(s1_gp_reg[5]);
        gz_sum  = 35'($signed(s1_c_reg[CI_Z])) + 35'(s1_gp_reg[6])
                  + 35'(s1_gp_reg[7]) + (35'(s1_gp_reg[8]) <<< 1);
        s_pure  = 66'(s1_sq_reg[0]) + 66'(s1_sq_reg[3]) + 66'(s1_sq_reg[5]);
        s_mixed = (66'(s1_sq_reg[1]) + 66'(s1_sq_reg[2]) + 66'(s1_sq_reg[4])) >> 1;
        s_tot   = s_pure + s_mixed;
    end

    // linear and quadratic terms, gradient, coefficient norm
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_lin_reg  <= 34'($signed(s1_c_reg[CI_ONE])) + 34'(s1_lin_reg[0])
                           + 34'(s1_lin_reg[1]) + 34'(s1_lin_reg[2]);
            s2_q_reg[0] <= qtd_qmul(s1_c_reg[CI_XX], s1_pp_reg[0]);
            s2_q_reg[1] <= qtd_qmul(s1_c_reg[CI_XY], s1_pp_reg[1]);
            s2_q_reg[2] <= qtd_qmul(s1_c_reg[CI_XZ], s1_pp_reg[2]);
            s2_q_reg[3] <= qtd_qmul(s1_c_reg[CI_YY], s1_pp_reg[3]);
            s2_q_reg[4] <= qtd_qmul(s1_c_reg[CI_YZ], s1_pp_reg[4]);
            s2_q_reg[5] <= qtd_qmul(s1_c_reg[CI_ZZ], s1_pp_reg[5]);
            s2_g_reg[0] <= qtd_sat32(48'(gx_sum));
            s2_g_reg[1] <= qtd_sat32(48'(gy_sum));
            s2_g_reg[2] <= qtd_sat32(48'(gz_sum));
            s2_s_reg    <= (s_tot[65:64] != 2'b00) ? '1 : s_tot[63:0];
        end
    end

    always_comb
    begin
        f_sum = 37'(s2_lin_reg) + 37'(s2_q_reg[0]) + 37'(s2_q_reg[1]) + 37'(s2_q_reg[2])
                + 37'(s2_q_reg[3]) + 37'(s2_q_reg[4]) + 37'(s2_q_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_f_reg      <= qtd_sat32(48'(f_sum));
            s3_g_reg      <= s2_g_reg;
            s3_gsq_reg[0] <= qtd_sq(s2_g_reg[0]);
            s3_gsq_reg[1] <= qtd_sq(s2_g_reg[1]);
            s3_gsq_reg[2] <= qtd_sq(s2_g_reg[2]);
            s3_s_reg      <= s2_s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_carry_reg.fv    <= s3_f_reg;
            s4_carry_reg.gx    <= s3_g_reg[0];
            s4_carry_reg.gy    <= s3_g_reg[1];
            s4_carry_reg.gz    <= s3_g_reg[2];
            s4_carry_reg.fmag  <= s3_f_reg[31] ? (~s3_f_reg + 32'd1) : s3_f_reg;
            s4_carry_reg.sval  <= s3_s_reg;
            s4_carry_reg.groot <= '0;
            s4_carry_reg.aroot <= '0;
            s4_gsum_reg        <= s3_gsq_reg[0] + s3_gsq_reg[1] + s3_gsq_reg[2];
        end
    end

    qtd_isqrt u_sqrt_grad
    (
        .clk       (clk),
        .en        (en),
        .value     (s4_gsum_reg),
        .carry_in  (s4_carry_reg),
        .root      (root1),
        .carry_out (carry1)
    );

    always_comb
    begin
        sq2_in       = carry1;
        sq2_in.groot = root1;
    end

    qtd_isqrt u_sqrt_norm
    (
        .clk       (clk),
        .en        (en),
        .value     (carry1.sval),
        .carry_in  (sq2_in),
        .root      (root2),
        .carry_out (carry2)
    );

    always_comb
    begin
        m1_in       = carry2;
        m1_in.aroot = root2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_carry_reg <= m1_in;
            m1_gg_reg    <= carry2.groot * carry2.groot;
            m1_af_reg    <= root2 * carry2.fmag;
            m2_carry_reg <= m1_carry_reg;
            m2_rv_reg    <= (m1_gg_reg >> 2) + m1_af_reg;
        end
    end

    qtd_isqrt u_sqrt_disc
    (
        .clk       (clk),
        .en        (en),
        .value     (m2_rv_reg),
        .carry_in  (m2_carry_reg),
        .root      (root3),
        .carry_out (carry3)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg.rem   <= '0;
            d0_reg.num   <= {carry3.fmag, 17'd0};
            d0_reg.quo   <= '0;
            d0_reg.den   <= 34'(carry3.groot) + {1'b0, root3, 1'b0};
            d0_reg.degen <= (carry3.groot == '0) && (carry3.aroot == '0)
                            && (carry3.fmag != '0);
            d0_reg.carry <= carry3;
        end
    end

    genvar i;
    for (i = 0; i < QTD_DIV_STEPS; i++)
    begin : g_div
        qtd_div_t prv;
        if (i == 0)
        begin : g_head
            assign prv = d0_reg;
        end
        else
        begin : g_body
            assign prv = dv_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[i] <= div_step(prv);
            end
        end
    end

    assign last = dv_reg[QTD_DIV_STEPS-1];

    always_comb
    begin
        if (last.carry.fmag == '0)
        begin
            dist_val = '0;
        end
        else if ((last.den == '0) || (last.quo[48:32] != '0))
        begin
            dist_val = '1;
        end
        else
        begin
            dist_val = last.quo[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg.distance_value <= dist_val;
            rsp_reg.field_value    <= last.carry.fv;
            rsp_reg.grad_x         <= last.carry.gx;
            rsp_reg.grad_y         <= last.carry.gy;
            rsp_reg.grad_z         <= last.carry.gz;
            rsp_reg.degenerate     <= last.degen;
        end
    end

endmodule

FILE: sv/quadric_taubin_distance_top.sv
// Pipeline: an accepted point request passes the 4-stage evaluate pipe, three 32-step
// square-root pipes and a 49-step divider before rsp_valid.
// Throughput: one request per cycle while rsp_ready does not stall the back pipe; load requests produce no response.
// A 2-entry queue between front and back takes two more point requests while rsp stalls.
// Reset: rst_n asynchronous active low; clears all coefficients, queue and valids.
module quadric_taubin_distance_top
    import qtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  qtd_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output qtd_rsp_t rsp
);

    logic     push_valid;
    logic     push_ready;
    qtd_job_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    qtd_job_t pop_data;

    qtd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_data)
    );

    qtd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    qtd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: sv/qtd_checker.sv
module qtd_checker
    import qtd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input qtd_rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("response changed while stalled");

    a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.degenerate |-> rsp.distance_value == 32'hffffffff)
        else $error("degenerate response without saturated distance");

    a_on_surface: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.field_value == 32'sd0 |-> rsp.distance_value == 32'd0
        && !rsp.degenerate)
        else $error("zero field with nonzero distance");

endmodule

bind quadric_taubin_distance_top qtd_checker u_qtd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
